>>> design/cs0_pkg.sv
package cs0_pkg;

  // Compression id that selects big-endian 16-bit code units
  localparam logic [7:0] WideId = 8'd16;

  // Code unit boundaries for the UTF-8 byte count
  localparam logic [15:0] TwoByteMin   = 16'h0080;
  localparam logic [15:0] ThreeByteMin = 16'h0800;

  // Lead and continuation byte prefixes
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [1:0] ContTag  = 2'b10;

  // Depth of the queue between front and back
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCountW  = $clog2(QDepth + 1);

  // One code unit waiting to be encoded
  typedef struct packed {
    logic [15:0] unit;
    logic        eos;
  } q_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  // Number of UTF-8 bytes for a code unit (1..3)
  function automatic logic [1:0] enc_len(input logic [15:0] u);
    logic [1:0] n;
    if (u < TwoByteMin) begin
      n = 2'd1;
    end else if (u < ThreeByteMin) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  // Byte at position idx of the UTF-8 encoding of u
  function automatic logic [7:0] enc_byte(input logic [15:0] u, input logic [1:0] idx);
    logic [1:0] n;
    logic [7:0] b;
    n = enc_len(u);
    b = u[7:0];
    if (n == 2'd2) begin
      b = (idx == 2'd0) ? {Lead2Tag, u[10:6]} : {ContTag, u[5:0]};
    end else if (n == 2'd3) begin
      unique case (idx)
        2'd0:    b = {Lead3Tag, u[15:12]};
        2'd1:    b = {ContTag, u[11:6]};
        default: b = {ContTag, u[5:0]};
      endcase
    end
    return b;
  endfunction

endpackage

>>> design/cs0_if.sv
interface cs0_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface cs0_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       end_of_string;

  modport source (output valid, output utf8_byte, output end_of_string, input ready);
  modport sink   (input valid, input utf8_byte, input end_of_string, output ready);
endinterface

>>> design/cs0_dstring_to_utf8.sv
// Compressed-unicode d-string to UTF-8 converter. Feed a string one byte per
// item on in_ch, with first_byte on the compression id byte and last_byte on
// the final byte; an id of 16 selects big-endian 16-bit code units, any other
// id one byte per character. Each code unit leaves on out_ch as 1, 2 or 3
// UTF-8 bytes, one byte per item, and end_of_string marks the last byte of a
// string. Surrogates are passed through unjoined, a lone trailing byte in
// 16-bit mode is sent as its own character, and an id-only string gives no
// output. The front takes one input item per cycle while its four-entry unit
// queue has room; the encoder behind it sends one output byte per cycle while
// out_ch is ready, so sustained rate is set by the output port, since each
// input byte yields at most 2 UTF-8 bytes. The first byte of a unit is written
// into the queue and then into the output register before it leaves on out_ch.
module cs0_dstring_to_utf8 (
  input  logic      clk,
  input  logic      rst_n,
  cs0_in_if.sink    in_ch,
  cs0_out_if.source out_ch
);
  import cs0_pkg::*;

  logic     push;
  logic     pop;
  q_entry_t push_entry;
  q_entry_t head;
  q_stat_t  q_stat;

  // Front: track mode and held high byte, build whole code units
  cs0_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue: decouple unit assembly from byte output
  cs0_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Back: expand each unit into UTF-8 bytes behind an output register
  cs0_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

>>> design/cs0_front.sv
module cs0_front (
  input  logic              clk,
  input  logic              rst_n,
  cs0_in_if.sink            in_ch,
  input  cs0_pkg::q_stat_t  q_stat,
  output logic              push,
  output cs0_pkg::q_entry_t push_entry
);
  import cs0_pkg::*;

  logic       wide_r, wide_nxt;
  logic       have_r, have_nxt;
  logic [7:0] high_r, high_nxt;
  logic       accept;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    wide_nxt         = wide_r;
    have_nxt         = have_r;
    high_nxt         = high_r;
    push             = 1'b0;
    push_entry.unit  = {8'h00, in_ch.data_byte};
    push_entry.eos   = in_ch.last_byte;
    if (accept) begin
      if (in_ch.first_byte) begin
        // id byte: pick mode, drop any held high byte
        wide_nxt = (in_ch.data_byte == WideId);
        have_nxt = 1'b0;
      end else if (wide_r && !have_r && !in_ch.last_byte) begin
        // hold high half of a 16-bit unit
        high_nxt = in_ch.data_byte;
        have_nxt = 1'b1;
      end else begin
        push     = 1'b1;
        have_nxt = 1'b0;
        if (wide_r && have_r) begin
          push_entry.unit = {high_r, in_ch.data_byte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0;
      have_r <= 1'b0;
    end else begin
      wide_r <= wide_nxt;
      have_r <= have_nxt;
    end
    high_r <= high_nxt;
  end

endmodule

>>> design/cs0_fifo.sv
module cs0_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cs0_pkg::q_entry_t push_entry,
  input  logic              pop,
  output cs0_pkg::q_entry_t head,
  output cs0_pkg::q_stat_t  q_stat
);
  import cs0_pkg::*;

  q_entry_t             mem_r [QDepth];
  logic [QPtrW-1:0]     wr_r, rd_r;
  logic [QCountW-1:0]   cnt_r, cnt_nxt;

  assign head             = mem_r[rd_r];
  assign q_stat.full      = (cnt_r == QCountW'(QDepth));
  assign q_stat.not_empty = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule

>>> design/cs0_back.sv
module cs0_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cs0_pkg::q_entry_t head,
  input  cs0_pkg::q_stat_t  q_stat,
  output logic              pop,
  cs0_out_if.source         out_ch
);
  import cs0_pkg::*;

  logic        busy_r, busy_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic [1:0]  len_r, len_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        eos_r, eos_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        oe_r, oe_nxt;
  logic        load;
  logic [1:0]  head_len;

  assign out_ch.valid         = ov_r;
  assign out_ch.utf8_byte     = ob_r;
  assign out_ch.end_of_string = oe_r;

  assign load     = !ov_r || out_ch.ready;
  assign head_len = enc_len(head.unit);

  always_comb begin
    busy_nxt = busy_r;
    unit_nxt = unit_r;
    len_nxt  = len_r;
    idx_nxt  = idx_r;
    eos_nxt  = eos_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    oe_nxt   = oe_r;
    pop      = 1'b0;
    if (load) begin
      if (busy_r) begin
        // continue the current unit
        ov_nxt  = 1'b1;
        ob_nxt  = enc_byte(unit_r, idx_r);
        oe_nxt  = eos_r && (idx_r == len_r - 2'd1);
        idx_nxt = idx_r + 2'd1;
        if (idx_r == len_r - 2'd1) begin
          busy_nxt = 1'b0;
        end
      end else if (q_stat.not_empty) begin
        // start a new unit with its lead byte
        pop      = 1'b1;
        ov_nxt   = 1'b1;
        ob_nxt   = enc_byte(head.unit, 2'd0);
        oe_nxt   = head.eos && (head_len == 2'd1);
        unit_nxt = head.unit;
        len_nxt  = head_len;
        idx_nxt  = 2'd1;
        eos_nxt  = head.eos;
        busy_nxt = (head_len != 2'd1);
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    unit_r <= unit_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    eos_r  <= eos_nxt;
    ob_r   <= ob_nxt;
    oe_r   <= oe_nxt;
  end

endmodule
